// ===== sv/dyn_arr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dyn_arr_pkg
// Shared types and constants for the dynamic array table unit: request and
// response words, operation and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package dyn_arr_pkg;

   localparam int MAX_ENTRIES_DEF = 256;
   localparam int DATA_WIDTH_DEF  = 32;
   localparam int INIT_CAP_DEF    = 8;

   localparam int KIND_W  = 2;
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;
   localparam int STAT_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_POP    = 2'd2,
      OP_GET    = 2'd3
   } op_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] entry_count;
      logic [COUNT_W-1:0] capacity_now;
      status_type         status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic shift;
      logic capture;
      logic emit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_kind_type kind;
      logic        op_ok;
      logic        remove_more;
      logic        shift_more;
   } dp_stat_type;

endpackage

// ===== sv/dyn_arr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dyn_arr_ctrl
// Sequencer for the dynamic array table unit: takes a request word, steps
// the datapath through execute, shift or read, and hands off the response.
// ----------------------------------------------------------------------------
module dyn_arr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  dyn_arr_pkg::dp_stat_type stat,
   output dyn_arr_pkg::ctl_cmd_type cmd
);
   import dyn_arr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_RDWAIT,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (!stat.op_ok) begin
               state_in = S_RESULT;
            end else begin
               case (stat.kind)
                  OP_APPEND: state_in = S_RESULT;
                  OP_REMOVE: state_in = stat.remove_more ? S_SHIFT : S_RESULT;
                  OP_POP:    state_in = S_RDWAIT;
                  OP_GET:    state_in = S_RDWAIT;
                  default:   state_in = S_RESULT;
               endcase
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (!stat.shift_more) begin
               state_in = S_RESULT;
            end
         end
         S_RDWAIT: begin
            cmd.capture = 1'b1;
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/dyn_arr_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dyn_arr_dpath
// Datapath for the dynamic array table unit: entry memory, count and
// capacity registers, shift pointer, status decode and response register.
// ----------------------------------------------------------------------------
module dyn_arr_dpath #(
   parameter int MAX_ENTRIES      = dyn_arr_pkg::MAX_ENTRIES_DEF,
   parameter int DATA_WIDTH       = dyn_arr_pkg::DATA_WIDTH_DEF,
   parameter int INITIAL_CAPACITY = dyn_arr_pkg::INIT_CAP_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dyn_arr_pkg::req_type     req_data,
   input  dyn_arr_pkg::ctl_cmd_type cmd,
   output dyn_arr_pkg::dp_stat_type stat,
   output dyn_arr_pkg::rsp_type     rsp_data
);
   import dyn_arr_pkg::*;

   localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW      = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_MAX = (MAX_ENTRIES > INITIAL_CAPACITY) ? MAX_ENTRIES : INITIAL_CAPACITY;
   localparam int CAPW    = $clog2(CAP_MAX + 1);
   localparam int SW      = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int IW      = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
   localparam int SHW     = ((CW + 2 > CAPW) ? CW + 2 : CAPW) + 1;

   op_kind_type        kind_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [SW-1:0]      value_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CAPW-1:0]    cap_ff, cap_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [SW-1:0]      rd_ff;
   logic [VALUE_W-1:0] res_data_ff, res_data_in;
   status_type         res_status_ff, res_status_in;
   rsp_type            rsp_ff;

   logic [SW-1:0]      mem [MAX_ENTRIES];

   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [SW-1:0]      mem_wd;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   logic [IW-1:0]      idx_w, cnt_w, ptr_w;
   logic               is_empty, is_full, idx_ok, remove_more, shift_more, op_ok;
   status_type         code;
   logic [CW-1:0]      cnt_dec;
   logic [CAPW-1:0]    shrink_cap, grow_cap;
   logic [CAPW:0]      dbl_cap;

   // decode
   always_comb begin
      idx_w       = IW'(idx_ff);
      cnt_w       = IW'(count_ff);
      ptr_w       = IW'(ptr_ff);
      is_empty    = (count_ff == '0);
      is_full     = (count_ff == CW'(MAX_ENTRIES));
      idx_ok      = (idx_w < cnt_w);
      remove_more = ((idx_w + IW'(1)) < cnt_w);
      shift_more  = ((ptr_w + IW'(2)) < cnt_w);
      cnt_dec     = count_ff - CW'(1);
      case (kind_ff)
         OP_APPEND: code = is_full ? ST_FULL : ST_OK;
         OP_REMOVE: code = is_empty ? ST_EMPTY : (idx_ok ? ST_OK : ST_RANGE);
         OP_POP:    code = is_empty ? ST_EMPTY : ST_OK;
         OP_GET:    code = idx_ok ? ST_OK : ST_RANGE;
         default:   code = ST_OK;
      endcase
      op_ok = (code == ST_OK);
      // shrink on new count after a removal
      if (((SHW'(cnt_dec) << 2) < SHW'(cap_ff)) &&
          (cap_ff > CAPW'(INITIAL_CAPACITY))) begin
         shrink_cap = cap_ff >> 1;
      end else begin
         shrink_cap = cap_ff;
      end
      // grow on append into a full logical capacity
      dbl_cap = (CAPW+1)'(cap_ff) << 1;
      if (SHW'(count_ff) >= SHW'(cap_ff)) begin
         if (dbl_cap > (CAPW+1)'(MAX_ENTRIES)) begin
            grow_cap = CAPW'(MAX_ENTRIES);
         end else begin
            grow_cap = CAPW'(dbl_cap);
         end
      end else begin
         grow_cap = cap_ff;
      end
   end

   // next state
   always_comb begin
      mem_we        = 1'b0;
      mem_wa        = AW'(count_ff);
      mem_wd        = value_ff;
      rd_en         = 1'b0;
      rd_addr       = AW'(idx_ff);
      count_in      = count_ff;
      cap_in        = cap_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      if (cmd.exec) begin
         res_status_in = code;
         res_data_in   = '0;
         if (op_ok) begin
            case (kind_ff)
               OP_APPEND: begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  cap_in   = grow_cap;
               end
               OP_REMOVE: begin
                  ptr_in = AW'(idx_ff);
                  if (remove_more) begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(idx_w + IW'(1));
                  end else begin
                     count_in = cnt_dec;
                     cap_in   = shrink_cap;
                  end
               end
               OP_POP: begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(cnt_dec);
                  count_in = cnt_dec;
                  cap_in   = shrink_cap;
               end
               OP_GET: begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(idx_ff);
               end
               default: begin
               end
            endcase
         end
      end
      if (cmd.shift) begin
         mem_we = 1'b1;
         mem_wa = ptr_ff;
         mem_wd = rd_ff;
         if (shift_more) begin
            rd_en   = 1'b1;
            rd_addr = AW'(ptr_w + IW'(2));
            ptr_in  = ptr_ff + AW'(1);
         end else begin
            count_in = cnt_dec;
            cap_in   = shrink_cap;
         end
      end
      if (cmd.capture) begin
         res_data_in = VALUE_W'(rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAPW'(INITIAL_CAPACITY);
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (cmd.load) begin
         kind_ff  <= req_data.kind;
         idx_ff   <= req_data.index;
         value_ff <= req_data.value[SW-1:0];
      end
      if (cmd.emit) begin
         rsp_ff.read_value   <= res_data_ff;
         rsp_ff.entry_count  <= COUNT_W'(count_ff);
         rsp_ff.capacity_now <= COUNT_W'(cap_ff);
         rsp_ff.status       <= res_status_ff;
      end
   end

   assign stat.kind        = kind_ff;
   assign stat.op_ok       = op_ok;
   assign stat.remove_more = remove_more;
   assign stat.shift_more  = shift_more;
   assign rsp_data         = rsp_ff;

endmodule

// ===== sv/dynamic_array_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_array_table_unit
// Bounded ordered list of data words with append, remove at index, pop and
// get; logical capacity doubles on a full append and halves on underuse.
// ----------------------------------------------------------------------------
//   channel   ports                          word
//   request   req_valid req_stall req_data   kind, index, value
//   response  rsp_valid rsp_stall rsp_data   read_value, entry_count,
//                                            capacity_now, status
//
// append and failed operations go through execute and result; get and pop
// add one registered memory read; remove moves the entries above the
// index down one at a time (count - index - 1 of them) through the single
// write port of the entry memory. one word is in work at a time; a new
// request is taken while the previous response is still held stalled.
// synchronous reset empties the list and sets capacity to its initial value.
// ----------------------------------------------------------------------------
module dynamic_array_table_unit #(
   parameter int MAX_ENTRIES      = dyn_arr_pkg::MAX_ENTRIES_DEF,
   parameter int DATA_WIDTH       = dyn_arr_pkg::DATA_WIDTH_DEF,
   parameter int INITIAL_CAPACITY = dyn_arr_pkg::INIT_CAP_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dyn_arr_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dyn_arr_pkg::rsp_type rsp_data
);
   import dyn_arr_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   dyn_arr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dyn_arr_dpath #(
      .MAX_ENTRIES      (MAX_ENTRIES),
      .DATA_WIDTH       (DATA_WIDTH),
      .INITIAL_CAPACITY (INITIAL_CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous word still in work");

   a_count_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= rsp_data.capacity_now))
      else $error("entry count above capacity");

   a_cap_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_data.capacity_now))
      else $error("capacity not a power of two");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.read_value == '0))
      else $error("failed operation returned data");

endmodule
